FILE: sv/lru_resident_set_loader_macros.svh
// Assertion macros used by the checker file of the resident set loader.
`ifndef LRU_RESIDENT_SET_LOADER_MACROS_SVH
`define LRU_RESIDENT_SET_LOADER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define LRSL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define LRSL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lrsl_pkg.sv
// Types and constants shared by the resident set loader modules.
package lrsl_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [2:0] STATUS_RESIDENT  = 3'd0;
  localparam logic [2:0] STATUS_LOADED    = 3'd1;
  localparam logic [2:0] STATUS_OVER      = 3'd2;
  localparam logic [2:0] STATUS_NO_VICTIM = 3'd3;
  localparam logic [2:0] STATUS_FAILED    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOP,
    ST_SCAN,
    ST_DRAIN,
    ST_EVICT
  } lrsl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_in;
    logic       scan_clr;
    logic       scan_issue;
    logic       evict;
    logic       load;
    logic       emit;
    logic       emit_kind;
    logic [2:0] emit_status;
  } lrsl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic need_evict;
    logic over;
    logic empty;
    logic fetch_ok;
    logic scan_last;
    logic out_free;
  } lrsl_stat_t;

endpackage

FILE: sv/lrsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lrsl_dp.sv
// Datapath: resident bits, stamp memory, access counter, oldest-entry scan and result register.
module lrsl_dp
  import lrsl_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic [3:0]       entry_index_i,
  input  logic             fetch_ok_i,
  input  lrsl_cmd_t        cmd_i,
  output lrsl_stat_t       stat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output logic [3:0]       victim_index_o,
  output logic [2:0]       status_o,
  output logic             last_o
);

  localparam int unsigned IW        = $clog2(NUM_ENTRIES);
  localparam int unsigned CNTW      = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned CMPW      = (CNTW > 6) ? CNTW : 6;
  localparam int unsigned MW        = (IW + 1 > 4) ? IW + 1 : 4;
  localparam int unsigned MOD_STEPS = 15 / NUM_ENTRIES;

  logic [CAP_W-1:0]   cap_q;
  logic [NUM_ENTRIES-1:0] res_q, res_d;
  logic [CNTW-1:0]    count_q, count_d;
  logic [STAMP_W-1:0] counter_q;
  logic [IW-1:0]      idx_q;
  logic               ok_q;
  logic [IW-1:0]      ptr_q;
  logic               rd_vld_q;
  logic [IW-1:0]      rd_idx_q;
  logic               found_q;
  logic [IW-1:0]      best_q;
  logic [STAMP_W-1:0] best_stamp_q;
  logic [STAMP_W-1:0] rdata;
  logic               better;
  logic [MW-1:0]      mod_v;
  logic               out_valid_q;
  logic               kind_q;
  logic [3:0]         victim_q;
  logic [2:0]         status_q;
  logic [CMPW-1:0]    cnt_ext, cap_ext;

  // Requested index reduced into the entry range by repeated subtraction.
  always_comb begin
    mod_v = MW'(entry_index_i);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (mod_v >= MW'(NUM_ENTRIES)) begin
        mod_v = mod_v - MW'(NUM_ENTRIES);
      end
    end
  end

  lrsl_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (NUM_ENTRIES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take_in),
    .waddr_i (mod_v[IW-1:0]),
    .wdata_i (counter_q),
    .re_i    (cmd_i.scan_issue),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    res_d   = res_q;
    count_d = count_q;
    if (cmd_i.evict) begin
      res_d[best_q] = 1'b0;
      count_d       = count_q - CNTW'(1);
    end else if (cmd_i.load) begin
      res_d[idx_q] = 1'b1;
      count_d      = count_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= '0;
      count_q     <= '0;
      counter_q   <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      res_q    <= res_d;
      count_q  <= count_d;
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.take_in && (counter_q != '1)) begin
        counter_q <= counter_q + STAMP_W'(1);
      end
      if (cmd_i.scan_clr) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Strict less-than keeps the lowest index on equal stamps.
  assign better = rd_vld_q && res_q[rd_idx_q] && (!found_q || (rdata < best_stamp_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      idx_q <= mod_v[IW-1:0];
      ok_q  <= fetch_ok_i;
    end
    if (cmd_i.scan_clr) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_issue) begin
      ptr_q <= ptr_q + IW'(1);
    end
    rd_idx_q <= ptr_q;
    if (better) begin
      best_q       <= rd_idx_q;
      best_stamp_q <= rdata;
    end
    if (cmd_i.emit) begin
      kind_q   <= cmd_i.emit_kind;
      victim_q <= (cmd_i.emit_kind == KIND_EVICT) ? 4'(best_q) : 4'd0;
      status_q <= (cmd_i.emit_kind == KIND_EVICT) ? STATUS_RESIDENT : cmd_i.emit_status;
    end
  end

  assign cnt_ext = CMPW'(count_q);
  assign cap_ext = CMPW'(cap_q);

  assign stat_o.hit        = res_q[idx_q];
  assign stat_o.need_evict = cnt_ext >= cap_ext;
  assign stat_o.over       = cnt_ext >= (cap_ext + CMPW'(2));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.fetch_ok   = ok_q;
  assign stat_o.scan_last  = (ptr_q == IW'(NUM_ENTRIES - 1));
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign victim_index_o = victim_q;
  assign status_o       = status_q;
  assign last_o         = kind_q;

endmodule

FILE: sv/lrsl_ctrl.sv
// Controller state machine sequencing lookup, eviction scans and result words.
module lrsl_ctrl
  import lrsl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lrsl_stat_t stat_i,
  output lrsl_cmd_t  cmd_o
);

  lrsl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat_i.hit) begin
          state_d = ST_LOOP;
        end else if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOP: begin
        if (stat_i.need_evict && !stat_i.over && !stat_i.empty) begin
          state_d = ST_SCAN;
        end else if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EVICT;
      end
      ST_EVICT: begin
        if (stat_i.out_free) begin
          state_d = ST_LOOP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.take_in = in_valid_i;
      end
      ST_CHECK: begin
        if (stat_i.hit && stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = KIND_FINAL;
          cmd_o.emit_status = STATUS_RESIDENT;
        end
      end
      ST_LOOP: begin
        if (stat_i.need_evict && !stat_i.over && !stat_i.empty) begin
          cmd_o.scan_clr = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_FINAL;
          if (!stat_i.need_evict) begin
            cmd_o.load        = stat_i.fetch_ok;
            cmd_o.emit_status = stat_i.fetch_ok ? STATUS_LOADED : STATUS_FAILED;
          end else if (stat_i.over) begin
            cmd_o.emit_status = STATUS_OVER;
          end else begin
            cmd_o.emit_status = STATUS_NO_VICTIM;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_EVICT: begin
        if (stat_i.out_free) begin
          cmd_o.evict     = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_EVICT;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: sv/lru_resident_set_loader.sv
// An already resident entry gives its word from the check state; others go on to the loop state first.
// Each eviction adds a scan: one stamp memory read per entry for the oldest search, then drain and evict.
// One request is handled at a time: a new one is taken only after the last gave its final word; output stalls add.
// Reset (asynchronous, active low) empties the resident set, zeroes the access counter,
// sets capacity to 4 and takes effect at once; stamps need no clearing.
module lru_resident_set_loader
  import lrsl_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [3:0]       entry_index_i,
  input  logic             fetch_ok_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output logic [3:0]       victim_index_o,
  output logic [2:0]       status_o,
  output logic             last_o
);

  lrsl_cmd_t  cmd;
  lrsl_stat_t stat;

  lrsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrsl_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .entry_index_i  (entry_index_i),
    .fetch_ok_i     (fetch_ok_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .victim_index_o (victim_index_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

FILE: sv/lrsl_checker.sv
// Port-level checker for the resident set loader and its bind.
`include "lru_resident_set_loader_macros.svh"

module lrsl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [4:0] cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [3:0] entry_index_i,
  input logic       fetch_ok_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       kind_o,
  input logic [3:0] victim_index_o,
  input logic [2:0] status_o,
  input logic       last_o
);

  // A stalled word stays on the port unchanged.
  `LRSL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(victim_index_o) && $stable(status_o) && $stable(last_o), "stalled output word changed")

  // Once a request is taken, no second one is taken in the next cycle.
  `LRSL_ASSERT_NXT(a_in_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request accepted while busy")

  // An eviction notice is never the closing word and carries status code 0 (resident).
  `LRSL_ASSERT_IMP(a_evict_word, clk_i, rst_ni, out_valid_o && !kind_o, !last_o && (status_o == 3'd0), "bad eviction notice")

  // A final status word names no victim and has a defined status code.
  `LRSL_ASSERT_IMP(a_final_word, clk_i, rst_ni, out_valid_o && kind_o, last_o && (victim_index_o == 4'd0) && (status_o <= 3'd4), "bad final status word")

endmodule

bind lru_resident_set_loader lrsl_checker u_lrsl_checker (.*);
